>>> hw/rtl/bsa_pkg.sv
// shared types, widths and codes of the bitmap slot allocator
`timescale 1ns / 1ps

package bsa_pkg;

    // field widths
    localparam int OFF_W = 20;
    localparam int ST_W  = 2;
    localparam int CNT_W = 9;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // bitmap word
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // default pool geometry
    localparam int RECORD_SLOTS_DEF = 64;
    localparam int BLOCK_SLOTS_DEF  = 256;
    localparam int BLOCK_BYTES_DEF  = 4096;
    localparam int RECORD_BASE_DEF  = 512;
    localparam int RECORD_BYTES_DEF = 256;

    // request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic POOL_REC  = 1'b0;
    localparam logic POOL_BLK  = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // divider request
    typedef struct packed {
        logic start;
        logic use_block;
    } bsa_div_req_t;

endpackage

>>> hw/rtl/bitmap_slot_allocator_top.sv
// first-fit slot allocator over an index record pool and a data block pool
// allocate: scans the bitmap words of the pool in order from the first until a free slot is found
//   (up to 2 words for records and 8 for blocks at the default pool sizes)
// free: reciprocal multiplier, word read and write; range status past pool, below record base
// one request at a time; the next is taken once the result enters the output register
// reset is synchronous active low; per-word valid flags make the bitmaps read as a
//   fresh image at once, with slot 0 of the record pool used and both counts zero
`timescale 1ns / 1ps

module bitmap_slot_allocator_top #(
    parameter int RECORD_SLOTS = bsa_pkg::RECORD_SLOTS_DEF,
    parameter int BLOCK_SLOTS  = bsa_pkg::BLOCK_SLOTS_DEF,
    parameter int BLOCK_BYTES  = bsa_pkg::BLOCK_BYTES_DEF,
    parameter int RECORD_BASE  = bsa_pkg::RECORD_BASE_DEF,
    parameter int RECORD_BYTES = bsa_pkg::RECORD_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // free_offset
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action, pool
    input  logic [bsa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot_offset, status, used_count
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import bsa_pkg::*;

    localparam int REC_WORDS = (RECORD_SLOTS + WORD_W - 1) / WORD_W;
    localparam int BLK_WORDS = (BLOCK_SLOTS + WORD_W - 1) / WORD_W;
    localparam int MAX_WORDS = (REC_WORDS > BLK_WORDS) ? REC_WORDS : BLK_WORDS;
    localparam int NWORDS    = REC_WORDS + BLK_WORDS;
    localparam int WW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int SLW       = WW + BIT_W;
    localparam int AW        = $clog2(NWORDS);
    localparam int RCW       = $clog2(RECORD_SLOTS + 1);
    localparam int BCW       = $clog2(BLOCK_SLOTS + 1);
    localparam int REC_TAIL  = RECORD_SLOTS % WORD_W;
    localparam int BLK_TAIL  = BLOCK_SLOTS % WORD_W;

    localparam logic [WORD_W-1:0] REC_TAIL_MASK =
        (REC_TAIL == 0) ? '0 : ~((WORD_W'(1) << REC_TAIL) - WORD_W'(1));
    localparam logic [WORD_W-1:0] BLK_TAIL_MASK =
        (BLK_TAIL == 0) ? '0 : ~((WORD_W'(1) << BLK_TAIL) - WORD_W'(1));
    localparam logic [WORD_W-1:0] REC_ROOT = WORD_W'(1);
    localparam logic [WW-1:0]     REC_LAST = WW'(REC_WORDS - 1);
    localparam logic [WW-1:0]     BLK_LAST = WW'(BLK_WORDS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_FWR  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [NWORDS-1:0]    valid_reg, valid_next;
    logic [RCW-1:0]       rec_cnt_reg, rec_cnt_next;
    logic [BCW-1:0]       blk_cnt_reg, blk_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 pool_reg, pool_next;
    logic [WW-1:0]        word_reg, word_next;
    logic [SLW-1:0]       slot_reg, slot_next;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [OFF_W-1:0]     off_reg, off_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    bsa_div_req_t         div_req;
    logic [OFF_W-1:0]     div_dividend;
    logic                 div_done;
    logic [OFF_W-1:0]     div_quo;

    logic                 in_pool;
    logic                 in_action;
    logic [OFF_W-1:0]     in_offs;
    logic                 below_base;
    logic [AW-1:0]        cur_addr;
    logic                 last_word;
    logic [WORD_W-1:0]    raw_word;
    logic [WORD_W-1:0]    scan_word;
    logic [WORD_W-1:0]    lowest_zero;
    logic [BIT_W-1:0]     zero_idx;
    logic                 has_zero;
    logic [WORD_W-1:0]    free_mask;
    logic                 quo_range;
    logic [31:0]          prod;
    logic [31:0]          cnt32;

    function automatic logic [AW-1:0] addr_of(input logic pool, input logic [WW-1:0] word);
        return AW'(word) + ((pool == POOL_BLK) ? AW'(REC_WORDS) : AW'(0));
    endfunction

    assign in_action  = s_axis_tuser[0];
    assign in_pool    = s_axis_tuser[1];
    assign in_offs    = s_axis_tdata[OFF_W-1:0];
    assign below_base = (32'(in_offs) < 32'(RECORD_BASE));

    assign cur_addr  = addr_of(pool_reg, word_reg);
    assign last_word = (word_reg == ((pool_reg == POOL_BLK) ? BLK_LAST : REC_LAST));
    assign raw_word  = valid_reg[cur_addr] ? ram_rdata :
                       ((pool_reg == POOL_REC && word_reg == '0) ? REC_ROOT : '0);
    assign scan_word = raw_word |
                       (last_word ? ((pool_reg == POOL_BLK) ? BLK_TAIL_MASK : REC_TAIL_MASK)
                                  : '0);
    assign lowest_zero = ~scan_word & (scan_word + WORD_W'(1));
    assign has_zero    = ~&scan_word;
    assign free_mask   = WORD_W'(1) << slot_reg[BIT_W-1:0];

    always_comb begin
        zero_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            zero_idx = zero_idx | (lowest_zero[i] ? BIT_W'(i) : '0);
        end
    end

    assign quo_range = (pool_reg == POOL_BLK) ? (32'(div_quo) >= 32'(BLOCK_SLOTS))
                                              : (32'(div_quo) >= 32'(RECORD_SLOTS));

    assign prod = (pool_reg == POOL_BLK)
                ? 32'(slot_reg) * 32'(BLOCK_BYTES)
                : 32'(RECORD_BASE) + 32'(slot_reg) * 32'(RECORD_BYTES);

    assign cnt32 = (pool_reg == POOL_BLK) ? 32'(blk_cnt_reg) : 32'(rec_cnt_reg);

    // bitmap port control
    always_comb begin
        case (state_reg)
            S_IDLE:  ram_raddr = addr_of(in_pool, '0);
            S_SCAN:  ram_raddr = last_word ? cur_addr : addr_of(pool_reg, word_reg + 1'b1);
            default: ram_raddr = cur_addr;
        endcase
        ram_we    = ((state_reg == S_SCAN) && has_zero) || (state_reg == S_FWR);
        ram_waddr = cur_addr;
        ram_wdata = (state_reg == S_SCAN) ? (raw_word | lowest_zero) : (raw_word & ~free_mask);
    end

    assign div_req.start     = (state_reg == S_IDLE) && s_axis_tvalid && (in_action == ACT_FREE)
                               && !((in_pool == POOL_REC) && below_base);
    assign div_req.use_block = (in_pool == POOL_BLK);
    assign div_dividend      = (in_pool == POOL_BLK) ? in_offs
                                                     : in_offs - OFF_W'(RECORD_BASE);

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        rec_cnt_next = rec_cnt_reg;
        blk_cnt_next = blk_cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pool_next    = pool_reg;
        word_next    = word_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        off_next     = off_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    pool_next = in_pool;
                    word_next = '0;
                    off_next  = '0;
                    if (in_action == ACT_ALLOC) begin
                        state_next = S_SCAN;
                    end else if ((in_pool == POOL_REC) && below_base) begin
                        status_next = ST_RANGE;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                if (has_zero) begin
                    slot_next   = {word_reg, zero_idx};
                    status_next = ST_OK;
                    if (pool_reg == POOL_BLK) begin
                        if (blk_cnt_reg < BCW'(BLOCK_SLOTS)) begin
                            blk_cnt_next = blk_cnt_reg + 1'b1;
                        end
                    end else begin
                        if (rec_cnt_reg < RCW'(RECORD_SLOTS)) begin
                            rec_cnt_next = rec_cnt_reg + 1'b1;
                        end
                    end
                    state_next = S_MUL;
                end else if (last_word) begin
                    status_next = ST_FULL;
                    state_next  = S_OUT;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_MUL: begin
                off_next   = prod[OFF_W-1:0];
                state_next = S_OUT;
            end
            S_DIV: begin
                if (div_done) begin
                    if (quo_range) begin
                        status_next = ST_RANGE;
                        state_next  = S_OUT;
                    end else begin
                        slot_next  = div_quo[SLW-1:0];
                        word_next  = div_quo[SLW-1:BIT_W];
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD: begin
                state_next = S_FWR;
            end
            S_FWR: begin
                status_next = ST_OK;
                if (pool_reg == POOL_BLK) begin
                    if (blk_cnt_reg != '0) begin
                        blk_cnt_next = blk_cnt_reg - 1'b1;
                    end
                end else begin
                    if (rec_cnt_reg != '0) begin
                        rec_cnt_next = rec_cnt_reg - 1'b1;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {1'b0, cnt32[CNT_W-1:0], status_reg, off_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            rec_cnt_reg <= '0;
            blk_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rec_cnt_reg <= rec_cnt_next;
            blk_cnt_reg <= blk_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        pool_reg   <= pool_next;
        word_reg   <= word_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        off_reg    <= off_next;
    end

    bsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsa_div #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(rec_cnt_reg) <= 32'(RECORD_SLOTS)) && (32'(blk_cnt_reg) <= 32'(BLOCK_SLOTS)))
        else $error("used count above pool size");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the free sequence");

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_SCAN) || (state_reg == S_FWR)))
        else $error("bitmap written outside scan or free update");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[OFF_W+ST_W-1:OFF_W] != ST_OK))
            |-> (m_data_reg[OFF_W-1:0] == '0))
        else $error("failed request carries a nonzero offset");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_OUT) && (!m_valid_reg || m_axis_tready)) |=> m_valid_reg)
        else $error("result not presented after completion");

endmodule

>>> hw/rtl/bsa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bsa_div.sv
// reciprocal multiplier that turns a byte offset into a slot number
`timescale 1ns / 1ps

module bsa_div #(
    parameter int BLOCK_BYTES  = bsa_pkg::BLOCK_BYTES_DEF,
    parameter int RECORD_BYTES = bsa_pkg::RECORD_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bsa_pkg::bsa_div_req_t      req,
    input  logic [bsa_pkg::OFF_W-1:0]  dividend,
    output logic                       done,
    output logic [bsa_pkg::OFF_W-1:0]  quotient
);

    import bsa_pkg::*;

    // floor(x / d) = (x * ceil(2^(OFF_W+l) / d)) >> (OFF_W+l), l = clog2(d), exact for x < 2^OFF_W
    localparam int     MUL_W     = OFF_W + 1;
    localparam int     PROD_W    = OFF_W + MUL_W;
    localparam int     BLK_SH    = OFF_W + $clog2(BLOCK_BYTES);
    localparam int     REC_SH    = OFF_W + $clog2(RECORD_BYTES);
    localparam longint BLK_RECIP =
        ((longint'(1) << BLK_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);
    localparam longint REC_RECIP =
        ((longint'(1) << REC_SH) + longint'(RECORD_BYTES) - 1) / longint'(RECORD_BYTES);
    localparam logic [MUL_W-1:0] BLK_MUL = MUL_W'(BLK_RECIP);
    localparam logic [MUL_W-1:0] REC_MUL = MUL_W'(REC_RECIP);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              blk_reg, blk_next;
    logic [OFF_W-1:0]  dvd_reg, dvd_next;
    logic [OFF_W-1:0]  quo_reg, quo_next;
    logic [MUL_W-1:0]  mul_sel;
    logic [PROD_W-1:0] prod;

    assign mul_sel = blk_reg ? BLK_MUL : REC_MUL;
    assign prod    = PROD_W'(dvd_reg) * PROD_W'(mul_sel);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        blk_next  = blk_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            blk_next  = req.use_block;
            dvd_next  = dividend;
        end else if (busy_reg) begin
            quo_next  = blk_reg ? OFF_W'(prod >> BLK_SH) : OFF_W'(prod >> REC_SH);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
